[rtl/uxv_pkg.sv]
// Shared types, constants and character-class function for the UTF-8 XML text validator.
package uxv_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned AccumW = 21;

   localparam logic [ByteW-1:0] CONT_LOW   = 8'h80;
   localparam logic [ByteW-1:0] CONT_HIGH  = 8'hBF;
   localparam logic [ByteW-1:0] ASCII_MAX  = 8'h7F;
   localparam logic [ByteW-1:0] LEAD2_MIN  = 8'hC2;
   localparam logic [ByteW-1:0] LEAD2_MAX  = 8'hDF;
   localparam logic [ByteW-1:0] LEAD3_MIN  = 8'hE0;
   localparam logic [ByteW-1:0] LEAD3_MAX  = 8'hEF;
   localparam logic [ByteW-1:0] LEAD3_SURR = 8'hED;
   localparam logic [ByteW-1:0] LEAD4_MIN  = 8'hF0;
   localparam logic [ByteW-1:0] LEAD4_MAX  = 8'hF4;
   localparam logic [ByteW-1:0] E0_LOW     = 8'hA0;
   localparam logic [ByteW-1:0] ED_HIGH    = 8'h9F;
   localparam logic [ByteW-1:0] F0_LOW     = 8'h90;
   localparam logic [ByteW-1:0] F4_HIGH    = 8'h8F;

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_ONE   = 2'd1;
   localparam logic [1:0] PEND_TWO   = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [1:0]        pending_count;
      logic [AccumW-1:0] point_accum;
      logic [ByteW-1:0]  next_low_bound;
      logic [ByteW-1:0]  next_high_bound;
      logic              error_seen;
   } uxv_state_type;

   localparam uxv_state_type STATE_RESET = '{
      pending_count:   PEND_NONE,
      point_accum:     '0,
      next_low_bound:  CONT_LOW,
      next_high_bound: CONT_HIGH,
      error_seen:      1'b0
   };

   // Legal XML 1.0 character: tab, LF, CR and the three allowed ranges.
   function automatic logic is_xml_char(input logic [AccumW-1:0] cp);
      return (cp == 21'h00009) || (cp == 21'h0000A) || (cp == 21'h0000D)
          || (cp >= 21'h00020 && cp <= 21'h0D7FF)
          || (cp >= 21'h0E000 && cp <= 21'h0FFFD)
          || (cp >= 21'h10000 && cp <= 21'h10FFFF);
   endfunction

endpackage

[rtl/uxv_step.sv]
// Per-byte decode step: next decoder state and end-of-text verdict.
module uxv_step (
   input  uxv_pkg::uxv_state_type     state_cur,
   input  logic [uxv_pkg::ByteW-1:0]  byte_value,
   input  logic                       last_byte,
   output uxv_pkg::uxv_state_type     state_nxt,
   output logic                       text_valid
);
   import uxv_pkg::*;

   uxv_state_type     upd;
   logic [AccumW-1:0] shifted;

   assign shifted = {state_cur.point_accum[AccumW-7:0], byte_value[5:0]};

   always_comb begin
      upd = state_cur;
      if (!state_cur.error_seen) begin
         if (state_cur.pending_count == PEND_NONE) begin
            upd.next_low_bound  = CONT_LOW;
            upd.next_high_bound = CONT_HIGH;
            priority if (byte_value <= ASCII_MAX) begin
               if (!is_xml_char({{(AccumW-ByteW){1'b0}}, byte_value}))
                  upd.error_seen = 1'b1;
            end else if (byte_value >= LEAD2_MIN && byte_value <= LEAD2_MAX) begin
               upd.point_accum   = {{(AccumW-5){1'b0}}, byte_value[4:0]};
               upd.pending_count = PEND_ONE;
            end else if (byte_value >= LEAD3_MIN && byte_value <= LEAD3_MAX) begin
               upd.point_accum   = {{(AccumW-4){1'b0}}, byte_value[3:0]};
               upd.pending_count = PEND_TWO;
               if (byte_value == LEAD3_MIN)  upd.next_low_bound  = E0_LOW;
               if (byte_value == LEAD3_SURR) upd.next_high_bound = ED_HIGH;
            end else if (byte_value >= LEAD4_MIN && byte_value <= LEAD4_MAX) begin
               upd.point_accum   = {{(AccumW-3){1'b0}}, byte_value[2:0]};
               upd.pending_count = PEND_THREE;
               if (byte_value == LEAD4_MIN) upd.next_low_bound  = F0_LOW;
               if (byte_value == LEAD4_MAX) upd.next_high_bound = F4_HIGH;
            end else begin
               upd.error_seen = 1'b1;
            end
         end else if (byte_value < state_cur.next_low_bound
                      || byte_value > state_cur.next_high_bound) begin
            upd.error_seen = 1'b1;
         end else begin
            upd.point_accum     = shifted;
            upd.pending_count   = state_cur.pending_count - 2'd1;
            upd.next_low_bound  = CONT_LOW;
            upd.next_high_bound = CONT_HIGH;
            // completed code point must be an XML character
            if (state_cur.pending_count == PEND_ONE && !is_xml_char(shifted))
               upd.error_seen = 1'b1;
         end
      end
   end

   assign text_valid = !upd.error_seen && (upd.pending_count == PEND_NONE);
   assign state_nxt  = last_byte ? STATE_RESET : upd;

endmodule

[rtl/utf8_xml_text_validator.sv]
// Top level of the streaming UTF-8 / XML 1.0 character text validator.
// rsp_valid rises once the last byte moves from the input stage into the result register.
// Throughput: one byte item per cycle unless a last byte stalls; uxv_step is combinational.
// Bytes without the last mark never wait on the result side; a last byte waits for space.
// Reset (synchronous, active high) empties both stages and clears the decoder state.
module utf8_xml_text_validator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [uxv_pkg::ByteW-1:0] req_byte_value,
   input  logic                      req_last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_text_valid
);
   import uxv_pkg::*;

   // input stage: one byte item waiting for the decode step
   logic             s1_valid_ff, s1_valid_in;
   logic [ByteW-1:0] s1_byte_ff,  s1_byte_in;
   logic             s1_last_ff,  s1_last_in;

   // decoder state carried from byte to byte
   uxv_state_type    state_ff, state_in;
   uxv_state_type    state_step;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic             out_text_ff,  out_text_in;

   logic             step_verdict;
   logic             s1_advance;
   logic             req_take;

   uxv_step u_step (
      .state_cur  (state_ff),
      .byte_value (s1_byte_ff),
      .last_byte  (s1_last_ff),
      .state_nxt  (state_step),
      .text_valid (step_verdict)
   );

   // A byte with no verdict always moves on; a last byte needs a free result slot.
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_byte_value;
         s1_last_in  = req_last_byte;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // advance decoder state only when the staged byte is consumed
   assign state_in = s1_advance ? state_step : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_text_in  = out_text_ff;
      if (s1_advance && s1_last_ff) begin
         out_valid_in = 1'b1;
         out_text_in  = step_verdict;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_last_ff  <= s1_last_in;
      out_text_ff <= out_text_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_text_valid = out_text_ff;

endmodule

[rtl/uxv_checker.sv]
// Port-level assertions for the UTF-8 XML text validator, bound to the top level.
module uxv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_byte,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_text_valid
);

   logic last_take;
   assign last_take = req_valid && req_ready && req_last_byte;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_valid))
      else $error("stalled result changed");

   // input back-pressure only while the result side is stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without result stall");

   // a fresh result follows a last byte through the input stage and the result register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(last_take, 2))
      else $error("result without a last byte");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind utf8_xml_text_validator uxv_checker u_uxv_checker (.*);

[dv/tb_utf8_xml_text_validator.sv]
// Self-checking testbench for the UTF-8 / XML 1.0 character text validator.
`timescale 1ns / 1ps

module tb_utf8_xml_text_validator;
   import uxv_pkg::*;

   // A silent stretch this long means the block has hung.
   localparam int unsigned IDLE_LIMIT = 500;
   // Watch on after the last verdict for any stray result.
   localparam int unsigned TAIL_CYCLES = 12;
   localparam int unsigned RANDOM_BYTES = 650;
   localparam int unsigned MAX_WAIT = 17;

   typedef struct {
      logic [ByteW-1:0] value;
      logic             last;
      int unsigned      gap;    // idle cycles before the item is offered
      bit               drain;  // hold the item until every verdict is back
   } text_byte_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [ByteW-1:0] req_byte_value = '0;
   logic             req_last_byte = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_text_valid;

   text_byte_type    byte_q[$];      // items waiting to be offered
   logic             verdict_q[$];   // predicted text_valid, oldest first
   logic [ByteW-1:0] text_bytes[$];  // text under construction
   int unsigned      sent_count = 0; // verdicts predicted (driver only)
   int unsigned      got_count = 0;  // verdicts received (monitor only)
   int unsigned      err_count = 0;

   // Predictor state of the decoder.
   logic [1:0]        dec_pend = PEND_NONE;
   logic [AccumW-1:0] dec_acc = '0;
   logic [ByteW-1:0]  dec_lo = CONT_LOW;
   logic [ByteW-1:0]  dec_hi = CONT_HIGH;
   logic              dec_bad = 1'b0;

   utf8_xml_text_validator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_text_valid (rsp_text_valid)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Tab, LF, CR and the three XML 1.0 ranges.
   function automatic logic xml_legal(input logic [AccumW-1:0] cp);
      return cp == 21'h9 || cp == 21'hA || cp == 21'hD
          || (cp >= 21'h20 && cp <= 21'hD7FF)
          || (cp >= 21'hE000 && cp <= 21'hFFFD)
          || (cp >= 21'h10000 && cp <= 21'h10FFFF);
   endfunction

   // Take one byte; on the marked byte give the verdict and clear the decoder.
   task automatic advance_decoder(input logic [ByteW-1:0] b, input logic last,
                                  output logic has_verdict, output logic verdict);
      // Once an error is seen, skip everything up to the marked byte.
      if (!dec_bad) begin
         if (dec_pend == PEND_NONE) begin
            dec_lo = CONT_LOW;
            dec_hi = CONT_HIGH;
            if (b <= ASCII_MAX) begin
               if (!xml_legal({13'd0, b})) dec_bad = 1'b1;
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               dec_acc  = {16'd0, b[4:0]};
               dec_pend = PEND_ONE;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               dec_acc  = {17'd0, b[3:0]};
               dec_pend = PEND_TWO;
               // Narrow the second byte: no overlong form, no surrogate.
               if (b == LEAD3_MIN) dec_lo = E0_LOW;
               if (b == LEAD3_SURR) dec_hi = ED_HIGH;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               dec_acc  = {18'd0, b[2:0]};
               dec_pend = PEND_THREE;
               // Narrow the second byte: no overlong form, nothing above 10FFFF.
               if (b == LEAD4_MIN) dec_lo = F0_LOW;
               if (b == LEAD4_MAX) dec_hi = F4_HIGH;
            end else begin
               dec_bad = 1'b1;
            end
         end else if (b < dec_lo || b > dec_hi) begin
            dec_bad = 1'b1;
         end else begin
            dec_acc  = {dec_acc[AccumW-7:0], b[5:0]};
            dec_pend = dec_pend - 2'd1;
            dec_lo   = CONT_LOW;
            dec_hi   = CONT_HIGH;
            if (dec_pend == PEND_NONE && !xml_legal(dec_acc)) dec_bad = 1'b1;
         end
      end
      has_verdict = last;
      // A sequence still open at the marked byte fails the text.
      verdict = !dec_bad && dec_pend == PEND_NONE;
      if (last) begin
         dec_pend = PEND_NONE;
         dec_acc  = '0;
         dec_lo   = CONT_LOW;
         dec_hi   = CONT_HIGH;
         dec_bad  = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------

   function automatic void put(input logic [ByteW-1:0] b);
      text_bytes.push_back(b);
   endfunction

   // Append the UTF-8 encoding of cp; surrogates encode too, as ED A0..BF.
   function automatic void put_point(input int unsigned cp);
      if (cp < 'h80) begin
         put(cp[7:0]);
      end else if (cp < 'h800) begin
         put(8'hC0 | cp[10:6]);
         put(8'h80 | cp[5:0]);
      end else if (cp < 'h10000) begin
         put(8'hE0 | cp[15:12]);
         put(8'h80 | cp[11:6]);
         put(8'h80 | cp[5:0]);
      end else begin
         put(8'hF0 | cp[20:18]);
         put(8'h80 | cp[17:12]);
         put(8'h80 | cp[11:6]);
         put(8'h80 | cp[5:0]);
      end
   endfunction

   // Turn the text under construction into items, marking its final byte.
   function automatic void close_text(input bit drain, input bit calm);
      text_byte_type it;
      for (int i = 0; i < text_bytes.size(); i++) begin
         it.value = text_bytes[i];
         it.last  = (i == text_bytes.size() - 1);
         it.gap   = calm ? 0 : $urandom_range(0, MAX_WAIT);
         it.drain = drain && i == 0;
         byte_q.push_back(it);
      end
      text_bytes.delete();
   endfunction

   // Mostly legal code points, biased toward range borders.
   function automatic int unsigned pick_point();
      int unsigned border_points[12] = '{'h09, 'h0A, 'h0D, 'h20, 'h7F, 'h80, 'h7FF,
                                         'h800, 'hD7FF, 'hE000, 'hFFFD, 'h10FFFF};
      if ($urandom_range(0, 2) == 0) return border_points[$urandom_range(0, 11)];
      case ($urandom_range(0, 3))
         0: return $urandom_range('h20, 'h7F);
         1: return $urandom_range('h80, 'h7FF);
         2: return ($urandom_range(0, 1) == 0) ? $urandom_range('h800, 'hD7FF)
                                                : $urandom_range('hE000, 'hFFFD);
         default: return $urandom_range('h10000, 'h10FFFF);
      endcase
   endfunction

   // One piece of a random text: legal char, noise, broken or illegal char.
   function automatic void put_piece();
      int unsigned kind;
      int unsigned mark;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         put_point(pick_point());
      end else if (kind < 68) begin
         put(ByteW'($urandom_range(0, 255)));
      end else if (kind < 80) begin
         // Lead byte followed by random continuation bytes: probes the bounds.
         put(ByteW'($urandom_range(LEAD2_MIN, LEAD4_MAX + 1)));
         repeat ($urandom_range(0, 3)) put(ByteW'($urandom_range(CONT_LOW, CONT_HIGH)));
      end else if (kind < 90) begin
         // Legal sequence cut short.
         mark = text_bytes.size();
         put_point($urandom_range('h80, 'h10FFFF));
         void'(text_bytes.pop_back());
         if (text_bytes.size() == mark) put(ByteW'($urandom_range(0, 255)));
      end else begin
         // Well-formed encoding of something XML forbids.
         case ($urandom_range(0, 3))
            0: put_point($urandom_range(0, 'h1F));
            1: put_point($urandom_range('hFFFE, 'hFFFF));
            2: put_point($urandom_range('hD800, 'hDFFF));
            default: put_point($urandom_range('h110000, 'h1FFFFF));
         endcase
      end
   endfunction

   initial begin
      int unsigned pieces;
      bit calm;

      // Directed texts: bounds of every lead class and each special case.
      put(8'h00); close_text(0, 0);                              // illegal control
      put(8'h09); close_text(0, 0);                              // tab
      put(8'h7F); put(8'h0D); close_text(0, 1);                  // ASCII top, CR
      put(8'hFF); close_text(0, 0);                              // bad lead
      put(8'hC2); put(8'h80); close_text(0, 1);                  // lowest 2-byte
      put(8'hDF); put(8'hBF); close_text(0, 0);                  // highest 2-byte
      put(8'hE0); put(8'h9F); put(8'hBF); close_text(0, 0);      // overlong, sticky
      put(8'hED); put(8'hA0); put(8'h80); close_text(0, 1);      // surrogate
      put(8'hEF); put(8'hBF); put(8'hBE); close_text(0, 0);      // FFFE
      put(8'hF0); put(8'h90); put(8'h80); put(8'h80); close_text(0, 0);
      put(8'hF4); put(8'h90); close_text(0, 1);                  // above 10FFFF
      put(8'hE2); put(8'h82); close_text(0, 0);                  // open at the end
      put(8'h80); close_text(0, 0);                              // stray continuation

      // Random texts; the first waits for all directed verdicts to drain.
      while (byte_q.size() < RANDOM_BYTES + 30) begin
         pieces = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 25)
                                               : $urandom_range(1, 5);
         repeat (pieces) put_piece();
         calm = ($urandom_range(0, 3) == 0);
         close_text(byte_q.size() < 40 || $urandom_range(0, 24) == 0, calm);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item is taken and every verdict has come back.
      do @(negedge clock);
      while (byte_q.size() != 0 || req_valid || got_count != sent_count);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (verdict_q.size() != 0) begin
         $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("tb_utf8_xml_text_validator: clean");
      end else begin
         $display("tb_utf8_xml_text_validator: errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: offer queued items, predict on each accepted one
   // ---------------------------------------------------------------------
   int unsigned gap_left = 0;
   bit          armed = 0;

   always @(posedge clock) begin
      logic             took;
      logic             has_verdict;
      logic             verdict;
      logic             nv;
      logic [ByteW-1:0] nb;
      logic             nl;
      text_byte_type    cur;
      if (reset) begin
         req_valid <= 1'b0;
         armed = 0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            advance_decoder(req_byte_value, req_last_byte, has_verdict, verdict);
            if (has_verdict) begin
               verdict_q.push_back(verdict);
               sent_count++;
            end
         end
         // Hold an item that is not yet taken; otherwise load the next one.
         nv = req_valid && !took;
         nb = req_byte_value;
         nl = req_last_byte;
         if (!nv && byte_q.size() != 0) begin
            if (!armed) begin
               gap_left = byte_q[0].gap;
               armed = 1;
            end
            // A drain item waits until the block has nothing left to report.
            if (!(byte_q[0].drain && sent_count != got_count)) begin
               if (gap_left != 0) begin
                  gap_left--;
               end else begin
                  cur = byte_q.pop_front();
                  nb = cur.value;
                  nl = cur.last;
                  nv = 1'b1;
                  armed = 0;
               end
            end
         end
         // One assignment per signal: a back-to-back item keeps valid high.
         req_valid      <= nv;
         req_byte_value <= nb;
         req_last_byte  <= nl;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: stall at random, check each verdict against the oldest guess
   // ---------------------------------------------------------------------
   int unsigned stall_left = 0;
   bit          rsp_calm = 0;

   always @(posedge clock) begin
      logic expected;
      logic nr;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, MAX_WAIT);
      end else begin
         nr = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: verdict %0b arrived, none expected", $time, rsp_text_valid);
               err_count++;
            end else begin
               expected = verdict_q.pop_front();
               if (rsp_text_valid !== expected) begin
                  $display("%0t: text_valid mismatch, expected %0b, got %0b",
                           $time, expected, rsp_text_valid);
                  err_count++;
               end
            end
            got_count <= got_count + 1;
            // Switch between stretches of stalls and stretches without.
            if ($urandom_range(0, 7) == 0) rsp_calm = !rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
            nr = (stall_left == 0);
         end else if (!rsp_ready) begin
            if (stall_left != 0) stall_left--;
            nr = (stall_left == 0);
         end
         rsp_ready <= nr;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run when neither channel moves for too long
   // ---------------------------------------------------------------------
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_utf8_xml_text_validator: errors");
            $finish;
         end
      end
   end

endmodule
